// File: rtl/core/pfn_pkg.sv
// ----------------------------------------------------------------------------
// pfn_pkg
// Shared types and constants for the polygon face normal block: the command
// and status records between controller and datapath, multiplier selects and
// iteration counts.
// ----------------------------------------------------------------------------
package pfn_pkg;

  // Default parameter values.
  localparam int MAX_FACE_VERTS_DEF = 64;
  localparam int COORD_WIDTH_DEF    = 24;

  // Q1.14 unit and result widths.
  localparam int NRM_W   = 16;
  localparam int SUM_W   = 21;
  localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

  // Vector and magnitude widths inside the normalizer.
  localparam int VEC_W   = 63;
  localparam int MAG_W   = 62;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 64;

  // Iteration counts of the shared units.
  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 15;
  localparam int ITER_W     = 5;

  // Multiplier operand selects: six cross-product terms, then three squares.
  localparam logic [3:0] MS_AYBZ = 4'd0;
  localparam logic [3:0] MS_AZBY = 4'd1;
  localparam logic [3:0] MS_AZBX = 4'd2;
  localparam logic [3:0] MS_AXBZ = 4'd3;
  localparam logic [3:0] MS_AXBY = 4'd4;
  localparam logic [3:0] MS_AYBX = 4'd5;
  localparam logic [3:0] MS_SQX  = 4'd6;
  localparam logic [3:0] MS_SQY  = 4'd7;
  localparam logic [3:0] MS_SQZ  = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       mul;
    logic       acc;
    logic [3:0] sel;
    logic       load;
    logic       src_sum;
    logic       shr;
    logic       shl;
    logic       sqrt_step;
    logic       div_step;
    logic       div_first;
    logic       div_last;
    logic [1:0] comp;
    logic       sum_add;
    logic       out_load;
    logic       dflt;
    logic       emit;
  } pfn_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tri_go;
    logic fend;
    logic zero;
    logic big;
    logic small_v;
    logic last;
  } pfn_sts_t;

endpackage

// File: rtl/core/pfn_dp.sv
// ----------------------------------------------------------------------------
// pfn_dp
// Datapath: face state, edge vectors, one shared 32x32 multiplier, the
// normalizing shifter, a bit-serial square root, a restoring divider, the
// running sum and the result register.
// ----------------------------------------------------------------------------
module pfn_dp #(
  parameter int MAX_FACE_VERTS = pfn_pkg::MAX_FACE_VERTS_DEF,
  parameter int COORD_WIDTH    = pfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfn_pkg::pfn_cmd_t             cmd,
  output pfn_pkg::pfn_sts_t             sts,
  input  logic signed [COORD_WIDTH-1:0] in_vx,
  input  logic signed [COORD_WIDTH-1:0] in_vy,
  input  logic signed [COORD_WIDTH-1:0] in_vz,
  input  logic                          in_face_end,
  output logic signed [15:0]            out_nx,
  output logic signed [15:0]            out_ny,
  output logic signed [15:0]            out_nz,
  output logic                          out_last_copy,
  output logic                          out_used_default,
  output logic                          out_too_long
);

  localparam int SH    = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int EW    = DW - SH;
  localparam int CNT_W = $clog2(MAX_FACE_VERTS + 1);
  localparam logic [DW-1:0] RND = DW'((64'd1 << SH) - 64'd1);
  localparam int NW = pfn_pkg::NRM_W;

  // Face state.
  logic signed [COORD_WIDTH-1:0] first_r [3];
  logic signed [COORD_WIDTH-1:0] prev_r  [3];
  logic signed [pfn_pkg::SUM_W-1:0] sum_r [3];
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  logic             tri_r;
  logic             end_r;

  // Edge vectors and cross product.
  logic signed [EW-1:0] ea_r [3];
  logic signed [EW-1:0] eb_r [3];
  logic signed [pfn_pkg::VEC_W-1:0] c_r [3];

  // Normalizer.
  logic [pfn_pkg::MAG_W-1:0] mag_r [3];
  logic                      neg_r [3];
  logic signed [pfn_pkg::PROD_W-1:0] prod_r;
  logic [pfn_pkg::PROD_W-1:0] sq_r;
  logic [pfn_pkg::PROD_W-1:0] sqx_r;
  logic [pfn_pkg::PROD_W-1:0] sqr_r;
  logic [pfn_pkg::PROD_W-1:0] bit_r;
  logic [31:0]                rem_r;
  logic [14:0]                q_r;
  logic signed [NW-1:0]       n_r [3];

  // Result register.
  logic signed [NW-1:0] onrm_r [3];
  logic                 dflt_r;
  logic                 tl_r;
  logic [CNT_W-1:0]     left_r;

  logic signed [COORD_WIDTH-1:0] vin [3];
  logic signed [EW-1:0] ea_nxt [3];
  logic signed [EW-1:0] eb_nxt [3];
  logic signed [pfn_pkg::MUL_W-1:0] opa;
  logic signed [pfn_pkg::MUL_W-1:0] opb;
  logic [pfn_pkg::PROD_W-1:0] sq_try;
  logic [30:0] len;
  logic [31:0] dt;
  logic        dge;
  logic [14:0] q_nxt;
  logic [pfn_pkg::MAG_W-1:0] dmag;

  assign vin[0] = in_vx;
  assign vin[1] = in_vy;
  assign vin[2] = in_vz;

  // Edge vectors from the first vertex, scaled with truncation toward zero.
  always_comb begin
    logic signed [DW-1:0] da;
    logic signed [DW-1:0] db;
    for (int i = 0; i < 3; i++) begin
      da = DW'(prev_r[i]) - DW'(first_r[i]);
      db = DW'(vin[i]) - DW'(first_r[i]);
      if (da < 0) begin
        da = da + $signed(RND);
      end
      if (db < 0) begin
        db = db + $signed(RND);
      end
      da = da >>> SH;
      db = db >>> SH;
      ea_nxt[i] = da[EW-1:0];
      eb_nxt[i] = db[EW-1:0];
    end
  end

  // Operand select of the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.sel)
      pfn_pkg::MS_AYBZ: begin opa = 32'(ea_r[1]); opb = 32'(eb_r[2]); end
      pfn_pkg::MS_AZBY: begin opa = 32'(ea_r[2]); opb = 32'(eb_r[1]); end
      pfn_pkg::MS_AZBX: begin opa = 32'(ea_r[2]); opb = 32'(eb_r[0]); end
      pfn_pkg::MS_AXBZ: begin opa = 32'(ea_r[0]); opb = 32'(eb_r[2]); end
      pfn_pkg::MS_AXBY: begin opa = 32'(ea_r[0]); opb = 32'(eb_r[1]); end
      pfn_pkg::MS_AYBX: begin opa = 32'(ea_r[1]); opb = 32'(eb_r[0]); end
      pfn_pkg::MS_SQX: begin
        opa = $signed({2'b00, mag_r[0][29:0]});
        opb = $signed({2'b00, mag_r[0][29:0]});
      end
      pfn_pkg::MS_SQY: begin
        opa = $signed({2'b00, mag_r[1][29:0]});
        opb = $signed({2'b00, mag_r[1][29:0]});
      end
      pfn_pkg::MS_SQZ: begin
        opa = $signed({2'b00, mag_r[2][29:0]});
        opb = $signed({2'b00, mag_r[2][29:0]});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Square root trial and divider step.
  assign sq_try = sqr_r + bit_r;
  assign len    = sqr_r[30:0];
  assign dmag   = mag_r[cmd.comp];
  assign dt     = cmd.div_first ? {2'b00, dmag[29:0]} : {rem_r[30:0], 1'b0};
  assign dge    = dt >= {1'b0, len};
  assign q_nxt  = {q_r[13:0], dge};

  // Status toward the controller.
  always_comb begin
    sts.tri_go  = tri_r;
    sts.fend    = end_r;
    sts.zero    = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
    sts.big     = (|mag_r[0][61:30]) | (|mag_r[1][61:30]) | (|mag_r[2][61:30]);
    sts.small_v = ~((|mag_r[0][61:29]) | (|mag_r[1][61:29]) | (|mag_r[2][61:29]));
    sts.last    = (left_r == CNT_W'(1));
  end

  // Face bookkeeping, result register and copy counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        first_r[i] <= '0;
        prev_r[i]  <= '0;
        sum_r[i]   <= '0;
      end
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      tri_r  <= 1'b0;
      end_r  <= 1'b0;
      left_r <= '0;
    end else begin
      if (cmd.accept) begin
        end_r <= in_face_end;
        if (cnt_r < CNT_W'(MAX_FACE_VERTS)) begin
          tri_r <= (cnt_r >= CNT_W'(2));
          for (int i = 0; i < 3; i++) begin
            if (cnt_r == '0) begin
              first_r[i] <= vin[i];
            end
            prev_r[i] <= vin[i];
            ea_r[i]   <= ea_nxt[i];
            eb_r[i]   <= eb_nxt[i];
          end
          cnt_r <= cnt_r + CNT_W'(1);
        end else begin
          tri_r <= 1'b0;
          ovf_r <= 1'b1;
        end
      end
      if (cmd.sum_add) begin
        for (int i = 0; i < 3; i++) begin
          sum_r[i] <= sum_r[i] + pfn_pkg::SUM_W'(n_r[i]);
        end
      end
      if (cmd.out_load) begin
        for (int i = 0; i < 3; i++) begin
          first_r[i] <= '0;
          prev_r[i]  <= '0;
          sum_r[i]   <= '0;
        end
        if (cmd.dflt) begin
          onrm_r[0] <= '0;
          onrm_r[1] <= pfn_pkg::ONE_Q14;
          onrm_r[2] <= '0;
        end else begin
          for (int i = 0; i < 3; i++) begin
            onrm_r[i] <= n_r[i];
          end
        end
        dflt_r <= cmd.dflt;
        tl_r   <= ovf_r;
        left_r <= cnt_r;
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (cmd.emit) begin
        left_r <= left_r - CNT_W'(1);
      end
    end
  end

  // Normalizer datapath: multiplier, shifter, square root and divider.
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= opa * opb;
    end
    if (cmd.acc) begin
      case (cmd.sel)
        pfn_pkg::MS_AYBZ: c_r[0] <= prod_r[62:0];
        pfn_pkg::MS_AZBY: c_r[0] <= c_r[0] - prod_r[62:0];
        pfn_pkg::MS_AZBX: c_r[1] <= prod_r[62:0];
        pfn_pkg::MS_AXBZ: c_r[1] <= c_r[1] - prod_r[62:0];
        pfn_pkg::MS_AXBY: c_r[2] <= prod_r[62:0];
        pfn_pkg::MS_AYBX: c_r[2] <= c_r[2] - prod_r[62:0];
        pfn_pkg::MS_SQX:  sq_r <= $unsigned(prod_r);
        pfn_pkg::MS_SQY:  sq_r <= sq_r + $unsigned(prod_r);
        pfn_pkg::MS_SQZ: begin
          sqx_r <= sq_r + $unsigned(prod_r);
          sqr_r <= '0;
          bit_r <= 64'd1 << 62;
        end
        default: sq_r <= sq_r;
      endcase
    end
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [pfn_pkg::VEC_W-1:0] cv;
        logic signed [pfn_pkg::VEC_W-1:0] av;
        cv = cmd.src_sum ? pfn_pkg::VEC_W'(sum_r[i]) : c_r[i];
        av = cv[pfn_pkg::VEC_W-1] ? -cv : cv;
        neg_r[i] <= cv[pfn_pkg::VEC_W-1];
        mag_r[i] <= av[pfn_pkg::MAG_W-1:0];
      end
    end else if (cmd.shr) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_r[i] >> 1;
      end
    end else if (cmd.shl) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_r[i] << 1;
      end
    end
    if (cmd.sqrt_step) begin
      if (sqx_r >= sq_try) begin
        sqx_r <= sqx_r - sq_try;
        sqr_r <= (sqr_r >> 1) + bit_r;
      end else begin
        sqr_r <= sqr_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.div_step) begin
      rem_r <= dge ? dt - {1'b0, len} : dt;
      q_r   <= q_nxt;
      if (cmd.div_last) begin
        n_r[cmd.comp] <= neg_r[cmd.comp] ? -NW'(q_nxt) : NW'(q_nxt);
      end
    end
  end

  assign out_nx           = onrm_r[0];
  assign out_ny           = onrm_r[1];
  assign out_nz           = onrm_r[2];
  assign out_last_copy    = (left_r == CNT_W'(1));
  assign out_used_default = dflt_r;
  assign out_too_long     = tl_r;

endmodule

// File: rtl/core/pfn_ctrl.sv
// ----------------------------------------------------------------------------
// pfn_ctrl
// Controller: sequences each fan triangle through cross product,
// normalization and summing; at face end, the final normalization and the result copies.
// ----------------------------------------------------------------------------
module pfn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  pfn_pkg::pfn_sts_t sts,
  output pfn_pkg::pfn_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ACC   = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;

  localparam int IW = pfn_pkg::ITER_W;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    step_r, step_nxt;
  logic [IW-1:0] iter_r, iter_nxt;
  logic [1:0]    comp_r, comp_nxt;
  logic          mode_r, mode_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_EMIT);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    iter_nxt  = iter_r;
    comp_nxt  = comp_r;
    mode_nxt  = mode_r;
    cmd       = '0;
    cmd.sel   = step_r;
    cmd.comp  = comp_r;
    cmd.src_sum = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.tri_go) begin
          mode_nxt  = 1'b0;
          step_nxt  = pfn_pkg::MS_AYBZ;
          state_nxt = S_MUL;
        end else if (sts.fend) begin
          mode_nxt  = 1'b1;
          state_nxt = S_LOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc  = 1'b1;
        step_nxt = step_r + 4'd1;
        if (step_r == pfn_pkg::MS_AYBX) begin
          state_nxt = S_LOAD;
        end else if (step_r == pfn_pkg::MS_SQZ) begin
          iter_nxt  = '0;
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.zero) begin
          if (mode_r) begin
            cmd.out_load = 1'b1;
            cmd.dflt     = 1'b1;
            state_nxt    = S_EMIT;
          end else if (sts.fend) begin
            mode_nxt  = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end else if (sts.big) begin
          cmd.shr = 1'b1;
        end else if (sts.small_v) begin
          cmd.shl = 1'b1;
        end else begin
          step_nxt  = pfn_pkg::MS_SQX;
          state_nxt = S_MUL;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + IW'(1);
        if (iter_r == IW'(pfn_pkg::SQRT_ITERS - 1)) begin
          iter_nxt  = '0;
          comp_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (iter_r == '0);
        cmd.div_last  = (iter_r == IW'(pfn_pkg::DIV_ITERS - 1));
        iter_nxt      = iter_r + IW'(1);
        if (cmd.div_last) begin
          iter_nxt = '0;
          if (comp_r == 2'd2) begin
            state_nxt = S_STORE;
          end else begin
            comp_nxt = comp_r + 2'd1;
          end
        end
      end
      S_STORE: begin
        if (mode_r) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          cmd.sum_add = 1'b1;
          if (sts.fend) begin
            mode_nxt  = 1'b1;
            state_nxt = S_LOAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          cmd.emit = 1'b1;
          if (sts.last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      iter_r  <= '0;
      comp_r  <= '0;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      iter_r  <= iter_nxt;
      comp_r  <= comp_nxt;
      mode_r  <= mode_nxt;
    end
  end

endmodule

// File: rtl/core/polygon_face_normal.sv
// ----------------------------------------------------------------------------
// polygon_face_normal
// Face normal of a polygon by fan triangulation, with normalized triangle
// normals summed and the sum normalized at face end, one copy per vertex, at most MAX_FACE_VERTS.
//
//   channel  direction  word
//   in_      input      vx, vy, vz (Q8.16), face_end
//   out_     output     nx, ny, nz (Q1.14), last_copy, used_default, too_long
//
// A fan triangle runs the cross product on the shared multiplier, the
// normalizing shifts, the squares, the square root and the three 15-step
// divisions. Face end adds one more normalization, then one copy per cycle
// while out_ready is high. Reset is synchronous and clears all face state.
// Input is taken only when idle; copies hold while out_ready is low.
// ----------------------------------------------------------------------------
module polygon_face_normal #(
  parameter int MAX_FACE_VERTS = pfn_pkg::MAX_FACE_VERTS_DEF,
  parameter int COORD_WIDTH    = pfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vx,
  input  logic signed [COORD_WIDTH-1:0] in_vy,
  input  logic signed [COORD_WIDTH-1:0] in_vz,
  input  logic                          in_face_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_nx,
  output logic signed [15:0]            out_ny,
  output logic signed [15:0]            out_nz,
  output logic                          out_last_copy,
  output logic                          out_used_default,
  output logic                          out_too_long
);

  pfn_pkg::pfn_cmd_t cmd;
  pfn_pkg::pfn_sts_t sts;

  // Sequencer.
  pfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and face state.
  pfn_dp #(
    .MAX_FACE_VERTS (MAX_FACE_VERTS),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_vx            (in_vx),
    .in_vy            (in_vy),
    .in_vz            (in_vz),
    .in_face_end      (in_face_end),
    .out_nx           (out_nx),
    .out_ny           (out_ny),
    .out_nz           (out_nz),
    .out_last_copy    (out_last_copy),
    .out_used_default (out_used_default),
    .out_too_long     (out_too_long)
  );

endmodule

// File: rtl/core/pfn_check.sv
// ----------------------------------------------------------------------------
// pfn_check
// Port-level checks on the face normal block, bound to the top level.
// ----------------------------------------------------------------------------
module pfn_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_nx,
  input logic signed [15:0] out_ny,
  input logic signed [15:0] out_nz,
  input logic               out_used_default,
  input logic               out_last_copy
);

  // A stalled word holds its normal.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nx) && $stable(out_ny)
      && $stable(out_nz) && $stable(out_last_copy))
    else $error("stalled word changed");

  // No vertex is taken while copies are being sent.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken during output");

  // The default normal is exactly (0, 1.0, 0).
  a_dflt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_used_default |-> out_nx == 16'sd0 && out_ny == 16'sd16384
      && out_nz == 16'sd0)
    else $error("bad default normal");

  // Components stay within the unit range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nx <= 16'sd16384 && out_nx >= -16'sd16384
      && out_ny <= 16'sd16384 && out_ny >= -16'sd16384
      && out_nz <= 16'sd16384 && out_nz >= -16'sd16384)
    else $error("normal out of range");

  // After the last copy the block is ready for the next vertex.
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_copy |=> in_ready)
    else $error("not idle after last copy");

endmodule

bind polygon_face_normal pfn_check u_pfn_check (.*);
